// ===== rtl/mor_pkg.sv =====
// mor_pkg: shared constants, types and codes for the median outlier replacer
// no dependencies

package mor_pkg;

   localparam int BlockLenDefault   = 64;
   localparam int SampleBitsDefault = 16;
   localparam int QueueDepth        = 4;
   localparam int QShift            = 7;
   localparam int CsrAddrBits       = 4;

   localparam logic [CsrAddrBits-3:0] CsrScale  = 2'd0;
   localparam logic [CsrAddrBits-3:0] CsrFactor = 2'd1;
   localparam logic [CsrAddrBits-3:0] CsrMin    = 2'd2;
   localparam logic [CsrAddrBits-3:0] CsrMax    = 2'd3;

   localparam logic [9:0] ScaleReset  = 10'd384;
   localparam logic [9:0] FactorReset = 10'd189;
   localparam logic [6:0] MinReset    = 7'd0;
   localparam logic [6:0] MaxReset    = 7'd10;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SEL1,
      ST_DEV,
      ST_SEL2,
      ST_THR,
      ST_FLAG,
      ST_EMIT
   } state_type;

endpackage

// ===== rtl/mor_front.sv =====
// mor_front: accepts samples and pushes them into a small queue
// depends on mor_pkg

module mor_front #(
   parameter int SAMPLE_BITS = mor_pkg::SampleBitsDefault,
   parameter int QDEPTH = mor_pkg::QueueDepth
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_sample_in,
   output logic                   q_valid,
   input  logic                   q_ready,
   output logic [SAMPLE_BITS-1:0] q_data
);
   import mor_pkg::*;

   localparam int PW = $clog2(QDEPTH);

   logic [SAMPLE_BITS-1:0] mem_ff [QDEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]   cnt_ff, cnt_in;
   logic push, pop;

   assign req_ready = (cnt_ff != (PW+1)'(QDEPTH));
   assign q_valid   = (cnt_ff != '0);
   assign q_data    = mem_ff[rd_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + {{PW{1'b0}}, push} - {{PW{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= req_sample_in;
   end

endmodule

// ===== rtl/mor_back.sv =====
// mor_back: stores a block, finds both medians, flags and emits samples
// depends on mor_pkg

module mor_back #(
   parameter int BLOCK_LEN   = mor_pkg::BlockLenDefault,
   parameter int SAMPLE_BITS = mor_pkg::SampleBitsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   output logic                   q_ready,
   input  logic [SAMPLE_BITS-1:0] q_data,
   input  logic [9:0]             scale_q7,
   input  logic [9:0]             factor_q7,
   input  logic [6:0]             min_cnt,
   input  logic [6:0]             max_cnt,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                   rsp_outlier_flag,
   output logic                   rsp_last_of_block
);
   import mor_pkg::*;

   localparam int AW   = $clog2(BLOCK_LEN);
   localparam int CW   = $clog2(BLOCK_LEN + 1);
   localparam int RANK = (BLOCK_LEN - 1) / 2;
   localparam int PB   = 20 + SAMPLE_BITS;
   localparam logic [AW-1:0] LastIdx = AW'(BLOCK_LEN - 1);

   // sample and deviation memories, one write port and two read ports each
   logic [SAMPLE_BITS-1:0] smem [BLOCK_LEN];
   logic [SAMPLE_BITS-1:0] dmem [BLOCK_LEN];
   logic                   fmem [BLOCK_LEN];

   state_type st_ff, st_in;
   logic [AW-1:0] ia_ff, ia_in, ib_ff, ib_in;
   logic [CW-1:0] less_ff, less_in, eq_ff, eq_in, ocnt_ff, ocnt_in;
   logic          sub_ff, sub_in;
   logic [SAMPLE_BITS-1:0] cand_ff, cand_in, med_ff, med_in, dmed_ff, dmed_in;
   logic [SAMPLE_BITS-1:0] rd_s, rd_d, rd_cand;
   logic                   rd_f;
   logic [PB-1:0] prod_ff, prod_in;
   logic [19:0]   sf_ff;
   logic          repl_ff, repl_in;
   logic          ov_ff, ov_in;
   logic [SAMPLE_BITS-1:0] os_ff, os_in;
   logic          of_ff, of_in, ol_ff, ol_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [AW-1:0] rd_idx_ff;

   logic s_we, d_we, f_we;
   logic [AW-1:0] s_wa, d_wa, f_wa, rd_a, rd_c;
   logic [SAMPLE_BITS-1:0] s_wd, d_wd;
   logic f_wd;
   logic sel_dev;
   logic lt, eqv, hit;
   logic signed [SAMPLE_BITS:0] diff;
   logic [SAMPLE_BITS-1:0] absd;
   logic [CW-1:0] less_n, eq_n;

   always_ff @(posedge clock) begin
      if (s_we) smem[s_wa] <= s_wd;
      if (d_we) dmem[d_wa] <= d_wd;
      if (f_we) fmem[f_wa] <= f_wd;
      rd_s    <= smem[rd_a];
      rd_d    <= dmem[rd_a];
      rd_f    <= fmem[rd_a];
      rd_cand <= sel_dev ? dmem[rd_c] : smem[rd_c];
   end

   // compare of the scanned element against the candidate
   always_comb begin
      if (sel_dev) begin
         lt  = rd_d < cand_ff;
         eqv = rd_d == cand_ff;
      end else begin
         lt  = $signed(rd_s) < $signed(cand_ff);
         eqv = rd_s == cand_ff;
      end
      less_n = less_ff + CW'(lt);
      eq_n   = eq_ff + CW'(eqv);
      hit    = (less_n <= CW'(RANK)) && (CW'(RANK) < less_n + eq_n);
      diff   = $signed({rd_s[SAMPLE_BITS-1], rd_s}) - $signed({med_ff[SAMPLE_BITS-1], med_ff});
      absd   = diff[SAMPLE_BITS] ? SAMPLE_BITS'(-diff) : diff[SAMPLE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      sf_ff <= scale_q7 * factor_q7;
   end

   always_comb begin
      st_in = st_ff; ia_in = ia_ff; ib_in = ib_ff;
      less_in = less_ff; eq_in = eq_ff; ocnt_in = ocnt_ff;
      sub_in = sub_ff;
      cand_in = cand_ff; med_in = med_ff; dmed_in = dmed_ff;
      prod_in = prod_ff; repl_in = repl_ff;
      ov_in = ov_ff; os_in = os_ff; of_in = of_ff; ol_in = ol_ff;
      rd_vld_in = 1'b0;
      s_we = 1'b0; s_wa = ia_ff; s_wd = q_data;
      d_we = 1'b0; d_wa = rd_idx_ff; d_wd = absd;
      f_we = 1'b0; f_wa = rd_idx_ff; f_wd = 1'b0;
      sel_dev = (st_ff == ST_SEL2);
      rd_a = ib_ff; rd_c = ia_ff;
      q_ready = 1'b0;
      if (ov_ff && rsp_ready) ov_in = 1'b0;
      unique case (st_ff)
         ST_LOAD: begin
            q_ready = 1'b1;
            if (q_valid) begin
               s_we = 1'b1;
               if (ia_ff == LastIdx) begin
                  st_in = ST_SEL1; ia_in = '0; ib_in = '0; sub_in = 1'b0;
               end else ia_in = ia_ff + 1'b1;
            end
         end
         ST_SEL1, ST_SEL2: begin
            // sub step 0 fetches candidate; then scan all elements
            if (!sub_ff) begin
               if (rd_vld_ff) begin
                  cand_in = rd_cand; sub_in = 1'b1; ib_in = '0;
                  less_in = '0; eq_in = '0;
               end else rd_vld_in = 1'b1;
            end else begin
               rd_vld_in = 1'b1;
               if (ib_ff != LastIdx) ib_in = ib_ff + 1'b1;
               if (rd_vld_ff) begin
                  less_in = less_n; eq_in = eq_n;
                  if (rd_idx_ff == LastIdx) begin
                     rd_vld_in = 1'b0; sub_in = 1'b0; ib_in = '0;
                     if (hit) begin
                        ia_in = '0;
                        if (st_ff == ST_SEL1) begin
                           med_in = cand_ff; st_in = ST_DEV;
                        end else begin
                           dmed_in = cand_ff; st_in = ST_THR;
                        end
                     end else ia_in = ia_ff + 1'b1;
                  end
               end
            end
         end
         ST_DEV: begin
            rd_vld_in = 1'b1;
            if (ib_ff != LastIdx) ib_in = ib_ff + 1'b1;
            if (rd_vld_ff) begin
               d_we = 1'b1;
               if (rd_idx_ff == LastIdx) begin
                  rd_vld_in = 1'b0; ib_in = '0; st_in = ST_SEL2; sub_in = 1'b0;
               end
            end
         end
         ST_THR: begin
            prod_in = PB'(sf_ff) * PB'(dmed_ff);
            st_in = ST_FLAG; ib_in = '0; ocnt_in = '0;
         end
         ST_FLAG: begin
            rd_vld_in = 1'b1;
            if (ib_ff != LastIdx) ib_in = ib_ff + 1'b1;
            if (rd_vld_ff) begin
               f_we = 1'b1;
               f_wd = (PB'(rd_d) << QShift) > (prod_ff >> QShift);
               ocnt_in = ocnt_ff + CW'(f_wd);
               if (rd_idx_ff == LastIdx) begin
                  rd_vld_in = 1'b0; ib_in = '0; st_in = ST_EMIT;
                  repl_in = (9'(ocnt_in) > 9'(min_cnt)) && (9'(ocnt_in) < 9'(max_cnt));
               end
            end
         end
         ST_EMIT: begin
            // one read in flight, emitted into the output register when free
            if (rd_vld_ff && (!ov_ff || rsp_ready)) begin
               ov_in = 1'b1;
               os_in = (repl_ff && rd_f) ? med_ff : rd_s;
               of_in = rd_f;
               ol_in = (rd_idx_ff == LastIdx);
               if (rd_idx_ff == LastIdx) begin
                  st_in = ST_LOAD; ia_in = '0; ib_in = '0;
               end else begin
                  rd_vld_in = 1'b1; ib_in = ib_ff + 1'b1;
               end
               rd_a = ib_ff;
            end else if (!rd_vld_ff) begin
               rd_vld_in = 1'b1; ib_in = ib_ff + 1'b1;
            end else begin
               rd_vld_in = 1'b1;
               rd_a = rd_idx_ff;
            end
         end
         default: st_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_LOAD; ia_ff <= '0; ib_ff <= '0; sub_ff <= 1'b0;
         rd_vld_ff <= 1'b0; ov_ff <= 1'b0; med_ff <= '0; dmed_ff <= '0;
      end else begin
         st_ff <= st_in; ia_ff <= ia_in; ib_ff <= ib_in; sub_ff <= sub_in;
         rd_vld_ff <= rd_vld_in; ov_ff <= ov_in; med_ff <= med_in; dmed_ff <= dmed_in;
      end
      rd_idx_ff <= rd_a;
      less_ff <= less_in; eq_ff <= eq_in; ocnt_ff <= ocnt_in;
      cand_ff <= cand_in; prod_ff <= prod_in;
      repl_ff <= repl_in; os_ff <= os_in; of_ff <= of_in; ol_ff <= ol_in;
   end

   assign rsp_valid         = ov_ff;
   assign rsp_sample_out    = os_ff;
   assign rsp_outlier_flag  = of_ff;
   assign rsp_last_of_block = ol_ff;

endmodule

// ===== rtl/mad_outlier_replacer.sv =====
// mad_outlier_replacer: top level with csr port, input queue and block engine
// depends on mor_pkg, mor_front, mor_back
//
// Samples are taken into a four-entry queue and loaded into a block store at
// one per cycle while the engine is loading and the queue holds a sample. When
// BLOCK_LEN samples are in, the engine finds the block median and the median
// of absolute deviations by rank selection: each candidate is compared against
// every stored value over one memory read port. A deviation pass, then
// threshold and flagging follow, and the block is then emitted at one beat per
// cycle while rsp_ready is high, with last_of_block on the final beat. The engine
// takes no new sample until the final beat is issued. The rank selection sets
// the pace. Registers: scale_q7 at 0x0, factor_q7 at 0x4, min_outlier_count at
// 0x8, max_outlier_count at 0xc; write them only while the block is idle.

module mad_outlier_replacer #(
   parameter int BLOCK_LEN   = mor_pkg::BlockLenDefault,
   parameter int SAMPLE_BITS = mor_pkg::SampleBitsDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [SAMPLE_BITS-1:0]          req_sample_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [SAMPLE_BITS-1:0]          rsp_sample_out,
   output logic                            rsp_outlier_flag,
   output logic                            rsp_last_of_block,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mor_pkg::CsrAddrBits-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import mor_pkg::*;

   logic [9:0] scale_ff, factor_ff;
   logic [6:0] min_ff, max_ff;
   logic q_valid, q_ready;
   logic [SAMPLE_BITS-1:0] q_data;
   logic wr;
   logic [CsrAddrBits-3:0] reg_idx;

   assign pready  = 1'b1;
   assign wr      = psel && penable && pwrite;
   assign reg_idx = paddr[CsrAddrBits-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= ScaleReset; factor_ff <= FactorReset;
         min_ff <= MinReset; max_ff <= MaxReset;
      end else if (wr) begin
         unique case (reg_idx)
            CsrScale:  scale_ff  <= pwdata[9:0];
            CsrFactor: factor_ff <= pwdata[9:0];
            CsrMin:    min_ff    <= pwdata[6:0];
            CsrMax:    max_ff    <= pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         CsrScale:  prdata = {22'd0, scale_ff};
         CsrFactor: prdata = {22'd0, factor_ff};
         CsrMin:    prdata = {25'd0, min_ff};
         CsrMax:    prdata = {25'd0, max_ff};
         default:   prdata = '0;
      endcase
   end

   mor_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_sample_in,
      .q_valid, .q_ready, .q_data
   );

   mor_back #(.BLOCK_LEN(BLOCK_LEN), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
      .clock, .reset, .q_valid, .q_ready, .q_data,
      .scale_q7(scale_ff), .factor_q7(factor_ff), .min_cnt(min_ff), .max_cnt(max_ff),
      .rsp_valid, .rsp_ready, .rsp_sample_out, .rsp_outlier_flag, .rsp_last_of_block
   );

endmodule

// ===== verif/mad_outlier_replacer_test.sv =====
// mad_outlier_replacer_test: self-checking bench for the block median outlier replacer
// depends on mor_pkg and mad_outlier_replacer; predicts each 64-sample block and
// checks every result beat in order

`timescale 1ns / 100ps

class block_scoreboard;
   logic signed [15:0] samples[64];
   int                 fill;
   logic [9:0]         scale, factor;
   logic [6:0]         min_cnt, max_cnt;
   logic [17:0]        pending[$];
   int                 mismatches;
   int                 beats_checked;
   int                 blocks_done;
   int                 replaced_blocks;

   function new();
      fill = 0;
      scale = mor_pkg::ScaleReset;
      factor = mor_pkg::FactorReset;
      min_cnt = mor_pkg::MinReset;
      max_cnt = mor_pkg::MaxReset;
      mismatches = 0;
      beats_checked = 0;
      blocks_done = 0;
      replaced_blocks = 0;
   endfunction

   function automatic longint rank_value(longint v[64], int k);
      int less, equal;
      for (int i = 0; i < 64; i++) begin
         less = 0;
         equal = 0;
         for (int j = 0; j < 64; j++) begin
            if (v[j] < v[i]) less++;
            else if (v[j] == v[i]) equal++;
         end
         if (less <= k && k < less + equal) return v[i];
      end
      return 0;
   endfunction

   function void note_sample(logic [15:0] s);
      longint vals[64], devs[64], med, dmed, thresh;
      bit flags[64];
      int count;
      bit repl;
      logic [15:0] outv;
      samples[fill] = s;
      fill++;
      if (fill < 64) return;
      fill = 0;
      for (int i = 0; i < 64; i++) vals[i] = longint'(samples[i]);
      med = rank_value(vals, 31);
      for (int i = 0; i < 64; i++)
         devs[i] = (vals[i] < med) ? med - vals[i] : vals[i] - med;
      dmed = rank_value(devs, 31);
      thresh = (longint'(scale) * longint'(factor) * dmed) >>> 7;
      count = 0;
      for (int i = 0; i < 64; i++) begin
         flags[i] = (devs[i] << 7) > thresh;
         count += flags[i];
      end
      repl = (count > min_cnt) && (count < max_cnt);
      if (repl && count > 0) replaced_blocks++;
      for (int i = 0; i < 64; i++) begin
         outv = (repl && flags[i]) ? med[15:0] : samples[i];
         pending.push_back({outv, flags[i], i == 63});
      end
   endfunction

   function void check_beat(logic [15:0] s, logic f, logic l);
      logic [17:0] exp_beat;
      beats_checked++;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected beat: %h %b %b", s, f, l);
         return;
      end
      exp_beat = pending.pop_front();
      if (exp_beat !== {s, f, l}) begin
         mismatches++;
         if (mismatches <= 10)
            $display("beat mismatch: exp sample %h flag %b last %b, got %h %b %b",
                     exp_beat[17:2], exp_beat[1], exp_beat[0], s, f, l);
      end
      if (l === 1'b1) blocks_done++;
   endfunction
endclass

module mad_outlier_replacer_test;
   import mor_pkg::*;

   localparam int WatchdogLimit = 40000;
   localparam int HoldCycles    = 12000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [15:0] req_sample_in = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [15:0] rsp_sample_out;
   logic        rsp_outlier_flag;
   logic        rsp_last_of_block;
   logic        psel = 0, penable = 0, pwrite = 0;
   logic [CsrAddrBits-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   block_scoreboard board;
   bit          hold_off = 0;
   bit          start_hold = 0;
   int          idle_cycles = 0;
   int          sent = 0;

   mad_outlier_replacer dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   function automatic int gap_len();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      return $urandom_range(0, 3);
   endfunction

   task automatic csr_write(logic [CsrAddrBits-3:0] idx, logic [31:0] value);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      @(posedge clock);
      case (idx)
         CsrScale:  board.scale = value[9:0];
         CsrFactor: board.factor = value[9:0];
         CsrMin:    board.min_cnt = value[6:0];
         default:   board.max_cnt = value[6:0];
      endcase
   endtask

   task automatic send_sample(logic [15:0] s);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1;
      req_sample_in <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_sample(s);
      sent++;
   endtask

   function automatic logic [15:0] pick_sample(int mode);
      case (mode)
         0: return 16'($signed($urandom_range(0, 200)) - 100);
         1: return 16'($urandom());
         2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
         default: return 16'($signed($urandom_range(0, 20)) + 1000);
      endcase
   endfunction

   // mostly a tight cluster with a few far outliers, some blocks fully random
   task automatic send_block(int style);
      int n_out;
      n_out = $urandom_range(0, 12);
      for (int i = 0; i < 64; i++) begin
         if (style == 1) send_sample(pick_sample(1));
         else if ($urandom_range(0, 63) < n_out) send_sample(pick_sample(2 * $urandom_range(0, 1) + 0 == 0 ? 1 : 2));
         else send_sample(pick_sample(style == 2 ? 3 : 0));
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // result side: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else if (hold_off) rsp_ready <= 0;
      else rsp_ready <= ($urandom_range(0, 9) < 2) ? 0 : 1;
      if (!reset && rsp_valid && rsp_ready)
         board.check_beat(rsp_sample_out, rsp_outlier_flag, rsp_last_of_block);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || hold_off || psel)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("watchdog expired with %0d beats pending", board.pending.size());
         $display("mad_outlier_replacer verification failed");
         $finish;
      end
   end

   // long receiver hold-off, counted here while the sender keeps going
   initial begin
      wait (start_hold);
      hold_off = 1;
      repeat (HoldCycles) @(posedge clock);
      hold_off = 0;
   end

   initial begin
      board = new();
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // two blocks back to back under hold-off: extremes, then a constant block
      start_hold = 1;
      for (int i = 0; i < 64; i++)
         send_sample(i < 6 ? (i[0] ? 16'h8000 : 16'h7fff) : 16'(i % 5));
      for (int i = 0; i < 64; i++) send_sample(16'h1234);
      drain();
      csr_write(CsrScale, 10'd1023);
      csr_write(CsrFactor, 10'd1023);
      csr_write(CsrMin, 7'd0);
      csr_write(CsrMax, 7'd65);
      send_block(0);
      drain();
      csr_write(CsrScale, 10'd0);
      csr_write(CsrFactor, 10'd0);
      csr_write(CsrMax, 7'd127);
      send_block(1);
      drain();
      csr_write(CsrScale, $urandom_range(0, 1023));
      csr_write(CsrFactor, $urandom_range(0, 1023));
      csr_write(CsrMin, $urandom_range(0, 127));
      csr_write(CsrMax, $urandom_range(0, 127));
      send_block(2);
      drain();
      $display("%0d samples sent, %0d blocks checked, %0d beats, %0d blocks replaced",
               sent, board.blocks_done, board.beats_checked, board.replaced_blocks);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("mad_outlier_replacer verification clean");
      else begin
         $display("%0d mismatches", board.mismatches);
         $display("mad_outlier_replacer verification failed");
      end
      $finish;
   end
endmodule
